### sv/bfa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator package
// Shared sizes, codes, payload types and the controller/datapath link types.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

  // Sizing of the frame map and of the address fields.
  localparam int MAX_FRAMES  = 4096;
  localparam int PAGE_BITS   = 12;
  localparam int WORD_BITS   = 32;
  localparam int ADDR_W      = 48;
  localparam int COUNT_W     = 13;
  localparam int FRAME_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int FRAME_W     = $clog2(MAX_FRAMES);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int WIDX_W      = $clog2(FRAME_WORDS);
  localparam int SCAN_W      = WIDX_W + 1;
  localparam int PFN_W       = ADDR_W - PAGE_BITS;

  localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = COUNT_W'(4096);
  localparam logic [COUNT_W-1:0] MAX_FRAMES_C      = COUNT_W'(MAX_FRAMES);

  // Request actions.
  typedef enum logic [1:0] {
    ACT_SET   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_TEST  = 2'd2,
    ACT_ALLOC = 2'd3
  } action_t;

  // Response status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    action_t             action;
    logic [ADDR_W-1:0]   phys_addr;
  } req_t;

  typedef struct packed {
    logic                in_use;
    logic [ADDR_W-1:0]   alloc_addr;
    status_t             status;
  } rsp_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCESS,
    S_SCAN,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic access;
    logic scan;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic alloc_req;
    logic scan_end;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

### sv/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator controller
// Sequences one request at a time: capture, word access or scan, result.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_ctrl
  import bfa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = sts.alloc_req ? S_SCAN : S_ACCESS;
        end
      end
      S_ACCESS: begin
        state_next = S_FINISH;
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output decode.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_ACCESS: begin
        cmd.access = 1'b1;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_FINISH: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/bfa_datapath.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator datapath
// Bitmap memory with per-word valid bits, request and result registers,
// the free-bit search and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_datapath
  import bfa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire req_t               in_data,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output rsp_t                    out_data,
  input  wire logic               cfg_we,
  input  wire logic [COUNT_W-1:0] cfg_wdata,
  input  wire ctrl_cmd_t          cmd,
  output ctrl_sts_t               sts
);

  // Bitmap storage; a word whose valid bit is low reads as all free.
  logic [WORD_BITS-1:0]   mem [FRAME_WORDS];
  logic [FRAME_WORDS-1:0] word_vld;
  logic [WORD_BITS-1:0]   rd_data_q;
  logic                   rd_vld_q;
  logic [WIDX_W-1:0]      rd_idx;
  logic                   mem_we;
  logic [WIDX_W-1:0]      wr_idx;
  logic [WORD_BITS-1:0]   wr_data;

  logic [COUNT_W-1:0]     frame_count;
  logic [COUNT_W-1:0]     live;
  action_t                action_q;
  logic [ADDR_W-1:0]      addr_q;
  logic [SCAN_W-1:0]      scan_word;
  logic [SCAN_W-1:0]      scan_next;
  rsp_t                   res;
  rsp_t                   res_next;
  logic                   res_we;

  logic [WORD_BITS-1:0]   cur;
  logic [PFN_W-1:0]       pfn;
  logic                   in_range;
  logic [BIT_W-1:0]       acc_bit;
  logic [WIDX_W-1:0]      acc_idx;
  logic [WORD_BITS-1:0]   acc_mask;
  logic                   word_live;
  logic                   word_full;
  logic [BIT_W-1:0]       free_bit;
  logic [FRAME_W-1:0]     free_frame;
  logic                   free_ok;
  logic                   found;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RESET;
    end else if (cfg_we) begin
      frame_count <= cfg_wdata;
    end
  end

  // A count above capacity saturates.
  assign live = (frame_count > MAX_FRAMES_C) ? MAX_FRAMES_C : frame_count;

  // Request capture and scan pointer.
  assign scan_next = scan_word + SCAN_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_q  <= in_data.action;
      addr_q    <= in_data.phys_addr;
      scan_word <= '0;
    end else if (cmd.scan) begin
      scan_word <= scan_next;
    end
  end

  // Read address: the request's word on capture, else the next scan word.
  always_comb begin
    if (cmd.capture) begin
      if (in_data.action == ACT_ALLOC) begin
        rd_idx = '0;
      end else begin
        rd_idx = in_data.phys_addr[PAGE_BITS+FRAME_W-1:PAGE_BITS+BIT_W];
      end
    end else begin
      rd_idx = scan_next[WIDX_W-1:0];
    end
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data_q <= mem[rd_idx];
    rd_vld_q  <= word_vld[rd_idx];
  end

  // Valid bits, cleared at once by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_vld <= '0;
    end else if (mem_we) begin
      word_vld[wr_idx] <= 1'b1;
    end
  end

  assign cur = rd_vld_q ? rd_data_q : '0;

  // Single-frame access decode.
  assign pfn      = addr_q[ADDR_W-1:PAGE_BITS];
  assign in_range = pfn < PFN_W'(live);
  assign acc_bit  = addr_q[PAGE_BITS+BIT_W-1:PAGE_BITS];
  assign acc_idx  = addr_q[PAGE_BITS+FRAME_W-1:PAGE_BITS+BIT_W];
  assign acc_mask = WORD_BITS'(1) << acc_bit;

  // Lowest clear bit of the current scan word.
  always_comb begin
    free_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!cur[i]) begin
        free_bit = BIT_W'(i);
      end
    end
  end

  assign word_live  = ADDR_W'({scan_word, {BIT_W{1'b0}}}) < ADDR_W'(live);
  assign word_full  = &cur;
  assign free_frame = {scan_word[WIDX_W-1:0], free_bit};
  assign free_ok    = ADDR_W'(free_frame) < ADDR_W'(live);
  assign found      = word_live && !word_full && free_ok;

  // Result and write-back for the access and scan steps.
  always_comb begin
    res_next = '0;
    res_we   = 1'b0;
    mem_we   = 1'b0;
    wr_idx   = acc_idx;
    wr_data  = cur;
    if (cmd.access) begin
      res_we = 1'b1;
      if (!in_range) begin
        res_next.status = ST_RANGE;
        res_next.in_use = (action_q == ACT_TEST);
      end else begin
        res_next.status = ST_OK;
        case (action_q)
          ACT_SET: begin
            mem_we  = 1'b1;
            wr_data = cur | acc_mask;
          end
          ACT_CLEAR: begin
            mem_we  = 1'b1;
            wr_data = cur & ~acc_mask;
          end
          ACT_TEST: begin
            res_next.in_use = cur[acc_bit];
          end
          default: begin
            res_next.in_use = 1'b0;
          end
        endcase
      end
    end else if (cmd.scan && sts.scan_end) begin
      res_we = 1'b1;
      if (found) begin
        res_next.status     = ST_OK;
        res_next.alloc_addr = ADDR_W'(free_frame) << PAGE_BITS;
        mem_we              = 1'b1;
        wr_idx              = scan_word[WIDX_W-1:0];
        wr_data             = cur | (WORD_BITS'(1) << free_bit);
      end else begin
        res_next.status = ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      res <= res_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= res;
    end
  end

  // Status to the controller.
  assign sts.alloc_req = (in_data.action == ACT_ALLOC);
  assign sts.scan_end  = !word_live || !word_full;
  assign sts.out_free  = !out_valid || !out_stall;

endmodule

`default_nettype wire

### sv/bitmap_frame_allocator_unit.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator
// One used bit per page frame; mark used, mark free, test, allocate lowest.
// ----------------------------------------------------------------------------
// Mark, free and test: the addressed word is read, updated in the access step,
// and the result is registered and then loaded into the output register.
// Allocate: bitmap words are scanned from word 0, one word a cycle through the
// single read port, until a word that is not full, or one past the count, is reached.
// The next request is taken only after the result enters the output register.
// Reset (synchronous) clears all per-word valid bits and sets the count to 4096.
`default_nettype none

module bitmap_frame_allocator_unit
  import bfa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire req_t               in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rsp_t                    out_data,
  input  wire logic               cfg_we,
  input  wire logic [COUNT_W-1:0] cfg_wdata
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer.
  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Bitmap, search and result path.
  bfa_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

### bench/bfa_checker.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator response checker
// Tracks the frame map and the managed frame count alongside the block,
// predicts the response to every accepted request and compares each
// accepted response, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfa_checker
  import bfa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  req_t               in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  rsp_t               out_data,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  output int                 mismatches,
  output int                 awaiting
);

  // Shadow copy of the used bits and of the frame count register.
  logic [WORD_BITS-1:0] used_map [FRAME_WORDS];
  logic [COUNT_W-1:0]   managed;
  rsp_t                 pending_rsp [$];

  // Apply one request to the shadow map and return the response it earns.
  function automatic rsp_t serve_request(req_t r);
    rsp_t        rsp;
    int unsigned live;
    int unsigned frame;
    logic [63:0] limit;
    bit          found;
    rsp        = '0;
    rsp.status = ST_OK;
    live       = (managed > MAX_FRAMES_C) ? MAX_FRAMES : int'(managed);
    limit      = 64'(live) << PAGE_BITS;
    found      = 1'b0;
    frame      = 0;
    if (r.action == ACT_ALLOC) begin
      // Lowest free frame below the count; full words are skipped whole.
      for (int w = 0; w < FRAME_WORDS && !found && w * WORD_BITS < live; w++) begin
        if (used_map[w] != '1) begin
          for (int b = 0; b < WORD_BITS && !found && w * WORD_BITS + b < live; b++) begin
            if (!used_map[w][b]) begin
              found = 1'b1;
              frame = w * WORD_BITS + b;
            end
          end
        end
      end
      if (found) begin
        used_map[frame / WORD_BITS][frame % WORD_BITS] = 1'b1;
        rsp.alloc_addr = ADDR_W'(frame) << PAGE_BITS;
      end else begin
        rsp.status = ST_FULL;
      end
    end else if ({16'b0, r.phys_addr} >= limit) begin
      // Beyond the managed range the map is left alone.
      rsp.status = ST_RANGE;
      if (r.action == ACT_TEST) rsp.in_use = 1'b1;
    end else begin
      frame = int'(r.phys_addr >> PAGE_BITS);
      case (r.action)
        ACT_SET:   used_map[frame / WORD_BITS][frame % WORD_BITS] = 1'b1;
        ACT_CLEAR: used_map[frame / WORD_BITS][frame % WORD_BITS] = 1'b0;
        default:   rsp.in_use = used_map[frame / WORD_BITS][frame % WORD_BITS];
      endcase
    end
    return rsp;
  endfunction

  // Responses are matched before new requests are predicted, so a response
  // leaving in the same cycle as a request arrives belongs to an older one.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      foreach (used_map[i]) used_map[i] = '0;
      managed = FRAME_COUNT_RESET;
      pending_rsp.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_rsp.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected response: expected none, actual in_use=%0b",
                   $time, out_data.in_use, " alloc_addr=%h status=%0d",
                   out_data.alloc_addr, out_data.status);
        end else begin
          want = pending_rsp.pop_front();
          if (out_data.in_use !== want.in_use || out_data.alloc_addr !== want.alloc_addr ||
              out_data.status !== want.status) begin
            mismatches++;
            $display("%0t: response mismatch: expected in_use=%0b alloc_addr=%h status=%0d",
                     $time, want.in_use, want.alloc_addr, want.status,
                     ", actual in_use=%0b alloc_addr=%h status=%0d",
                     out_data.in_use, out_data.alloc_addr, out_data.status);
          end
        end
      end
      if (cfg_we) managed = cfg_wdata;
      if (in_valid && !in_stall) pending_rsp.push_back(serve_request(in_data));
    end
    awaiting <= pending_rsp.size();
  end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator testbench
// Drives directed and random mark, free, test and allocate requests under
// several frame counts and idle patterns, with a separate checker watching
// both channels; reports the verdict once every response has come back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import bfa_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  req_t               in_data   = '0;
  logic               out_stall = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;
  logic               in_stall;
  logic               out_valid;
  rsp_t               out_data;
  int                 mismatches;
  int                 awaiting;

  // Idle pattern of the current phase and the frame count last written.
  int          idle_pct  = 0;
  int          stall_pct = 0;
  bit          hold_req  = 1'b0;
  int          hold_left = 0;
  int unsigned cur_count = 4096;
  int unsigned cycles    = 0;

  always #5 clk = ~clk;

  bitmap_frame_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  bfa_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  // Response side: random stalls, or one long hold-off when asked for.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Present one request after a random idle gap and wait until it is taken.
  task automatic offer(input action_t act, input logic [ADDR_W-1:0] addr);
    req_t r;
    int   gap;
    r.action    = act;
    r.phys_addr = addr;
    gap         = 0;
    while (gap < 60 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop requesting and wait until every predicted response has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  // Frame count is only changed while the block is idle.
  task automatic write_count(input logic [COUNT_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    cur_count = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random request, mostly aimed at frames near the managed range.
  task automatic random_request();
    action_t           act;
    logic [ADDR_W-1:0] addr;
    int unsigned       live;
    int unsigned       frame;
    int unsigned       pick;
    live = (cur_count > MAX_FRAMES) ? MAX_FRAMES : cur_count;
    pick = $urandom_range(99);
    if (pick < 35)      act = ACT_ALLOC;
    else if (pick < 55) act = ACT_SET;
    else if (pick < 78) act = ACT_CLEAR;
    else                act = ACT_TEST;
    pick = $urandom_range(99);
    if (pick < 75) begin
      frame = $urandom_range(live + 1);
      addr  = (ADDR_W'(frame) << PAGE_BITS) | ADDR_W'($urandom_range(4095));
    end else if (pick < 88) begin
      addr = ADDR_W'({$urandom(), $urandom()});
    end else begin
      frame = (live == 0) ? 0 : live - $urandom_range(1);
      addr  = (ADDR_W'(frame) << PAGE_BITS) | ($urandom_range(1) ? ADDR_W'(12'hFFF) : '0);
    end
    offer(act, addr);
  endtask

  // Watchdog on the total run length.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned phase_counts [10];
    phase_counts = '{4096, 40, 33, 1, 100, 8191, 64, 0, 2000, 31};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests at the reset frame count.
    offer(ACT_TEST, 48'h0);
    offer(ACT_ALLOC, 48'h0);
    offer(ACT_ALLOC, 48'h0);
    offer(ACT_TEST, 48'h1000);
    offer(ACT_CLEAR, 48'h1FFF);
    offer(ACT_ALLOC, '1);
    offer(ACT_SET, 48'hFF_FFFF);
    offer(ACT_TEST, 48'hFF_F123);
    offer(ACT_SET, 48'h100_0000);
    offer(ACT_TEST, '1);
    offer(ACT_CLEAR, 48'h100_0000);
    offer(ACT_CLEAR, 48'hFF_F000);
    offer(ACT_TEST, 48'hFF_F000);

    // With no frames managed everything is out of range or full.
    write_count(0);
    offer(ACT_ALLOC, 48'h0);
    offer(ACT_TEST, 48'h0);
    offer(ACT_SET, 48'h0);

    // A tiny map fills after one more allocation.
    write_count(3);
    offer(ACT_ALLOC, 48'h0);
    offer(ACT_ALLOC, 48'h0);
    offer(ACT_TEST, 48'h2ABC);

    // A count above capacity saturates at the map size.
    write_count(8191);
    offer(ACT_TEST, 48'hFF_FFFF);
    offer(ACT_SET, 48'h100_0000);
    offer(ACT_ALLOC, 48'h0);

    // Random phases under varying counts and idle patterns.
    for (int p = 0; p < 10; p++) begin
      write_count(phase_counts[p]);
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 80;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 80;
        end
        default: begin
          idle_pct  = 7;
          stall_pct = 7;
        end
      endcase
      if (p == 0) hold_req = 1'b1;
      repeat (85) random_request();
    end

    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
sv/bfa_pkg.sv
sv/bfa_ctrl.sv
sv/bfa_datapath.sv
sv/bitmap_frame_allocator_unit.sv
bench/bfa_checker.sv
bench/testbench.sv
